// ===== rtl/core/mtf_pkg.sv =====
package mtf_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ITEM_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int unsigned OUT_COUNT_W = 5;
  localparam int unsigned OUT_DATA_W  = ((2 + OUT_COUNT_W + 7) / 8) * 8;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_ACCESS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One list slot as it moves from cell to cell.
  typedef struct packed {
    logic   valid;
    value_t value;
  } mtf_entry_t;

  // Command broadcast to every cell for the beat being taken.
  typedef struct packed {
    value_t key;
    logic   insert_en;
    logic   access_en;
  } mtf_cmd_t;

endpackage

// ===== rtl/core/mtf_cell.sv =====
module mtf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtf_pkg::mtf_cmd_t   cmd_i,
  input  logic               found_i,
  input  mtf_pkg::mtf_entry_t prev_i,
  input  logic               hit_i,
  output mtf_pkg::mtf_entry_t entry_o,
  output logic               hit_o
);
  import mtf_pkg::*;

  logic   valid_q, valid_d;
  value_t value_q, value_d;
  logic   match;
  logic   load;

  assign match = valid_q && (value_q == cmd_i.key);
  assign hit_o = hit_i | match;

  // Shift on insert; on access shift every cell up to and including the
  // frontmost match.
  assign load = cmd_i.insert_en | (cmd_i.access_en & found_i & ~hit_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (load) begin
      valid_d = prev_i.valid;
      value_d = prev_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.value = value_q;

endmodule

// ===== rtl/core/move_to_front_list_unit.sv =====
// Channel   Dir  tdata                                  tuser
// s_axis    in   [31:0] item_value                      [0] kind
// m_axis    out  [1:0] status, [6:2] entry_count, pad   -
//
// One beat per cycle unless a stalled result blocks input: every cell
// compares against the key in parallel and the frontmost-match chain
// through the cells picks the shift span. Result appears in the cycle
// after the input beat, from the output register. Reset empties the list
// (valid bits and count clear); entry values hold. A stalled result blocks
// input only while the output register is full and m_axis_tready is low.
module move_to_front_list_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [mtf_pkg::ITEM_WIDTH-1:0]    s_axis_tdata_i,   // [31:0] item_value
  input  logic                              s_axis_tuser_i,   // [0] kind
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [mtf_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o    // [1:0] status, [6:2] entry_count
);
  import mtf_pkg::*;

  mtf_cmd_t   cmd;
  mtf_entry_t link [DEPTH+1];
  logic       hit  [DEPTH+1];
  logic [DEPTH-1:0] valid_vec;
  logic       accept;
  logic       full;
  logic       found;
  kind_e      kind;

  count_t     count_q, count_d;
  logic       out_valid_q;
  status_e    out_status_q, status_d;
  logic [OUT_COUNT_W-1:0] out_count_q;

  assign kind   = kind_e'(s_axis_tuser_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign full   = link[DEPTH].valid;
  assign found  = hit[DEPTH];

  assign cmd.key       = value_t'($signed(s_axis_tdata_i));
  assign cmd.insert_en = accept && (kind == KIND_INSERT) && !full;
  assign cmd.access_en = accept && (kind == KIND_ACCESS);

  // Front cell takes the key as a fresh valid entry.
  assign link[0].valid = 1'b1;
  assign link[0].value = cmd.key;
  assign hit[0]        = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mtf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .found_i (found),
      .prev_i  (link[g]),
      .hit_i   (hit[g]),
      .entry_o (link[g+1]),
      .hit_o   (hit[g+1])
    );
    assign valid_vec[g] = link[g+1].valid;
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_NOT_FOUND;
    unique case (kind)
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + count_t'(1);
        end
      end
      KIND_ACCESS: begin
        status_d = found ? ST_FOUND : ST_NOT_FOUND;
      end
      default: status_d = ST_NOT_FOUND;
    endcase
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold result payload until the next beat is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
      out_count_q  <= OUT_COUNT_W'(count_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_count_q, out_status_q});

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("entry count disagrees with cell valid bits");

  a_valid_packed_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("valid cells not packed at the front");

  a_found_moves_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.access_en && found |=> link[1].valid && (link[1].value == $past(cmd.key)))
    else $error("found entry not at front after access");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind == KIND_INSERT) && full |=> $stable(count_q) && (out_status_q == ST_FULL))
    else $error("insert into full list changed count or status");

endmodule

// ===== verif/move_to_front_list_checker.sv =====
`timescale 1ns / 1ps

module move_to_front_list_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [mtf_pkg::ITEM_WIDTH-1:0] s_axis_tdata_i,   // [31:0] item_value
  input  logic                           s_axis_tuser_i,   // [0] kind
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [mtf_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,   // [1:0] status, [6:2] entry_count
  output int unsigned                    error_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    found_count_o,
  output int unsigned                    rejected_count_o
);
  import mtf_pkg::*;

  typedef struct packed {
    status_e                status;
    logic [OUT_COUNT_W-1:0] count;
  } list_result_t;

  value_t         entries [DEPTH];
  int unsigned    held;
  list_result_t   results_due [$];
  list_result_t   due;
  status_e        seen_status;
  logic [4:0]     seen_count;

  // Apply one beat to the shadow list and return the result it must produce.
  task automatic advance_list(input kind_e kind, input value_t key, output list_result_t res);
    int hit;
    hit = -1;
    if (kind == KIND_INSERT) begin
      if (held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (int i = DEPTH - 1; i > 0; i--) entries[i] = entries[i-1];
        entries[0] = key;
        held++;
        res.status = ST_INSERTED;
      end
    end else begin
      // frontmost match wins
      for (int i = 0; i < held; i++) begin
        if (hit < 0 && entries[i] == key) hit = i;
      end
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (int i = hit; i > 0; i--) entries[i] = entries[i-1];
        entries[0] = key;
        res.status = ST_FOUND;
      end
    end
    res.count = OUT_COUNT_W'(held);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held             = 0;
      results_due.delete();
      error_count_o    = 0;
      pending_o        = 0;
      found_count_o    = 0;
      rejected_count_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        advance_list(kind_e'(s_axis_tuser_i), value_t'(s_axis_tdata_i), due);
        results_due.push_back(due);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen_status = status_e'(m_axis_tdata_i[1:0]);
        seen_count  = m_axis_tdata_i[6:2];
        if (results_due.size() == 0) begin
          $display("%0t checker: result beat with nothing expected, status %0d count %0d",
                   $time, seen_status, seen_count);
          error_count_o++;
        end else begin
          due = results_due.pop_front();
          if (seen_status !== due.status) begin
            $display("%0t checker: status expected %0d, actual %0d",
                     $time, due.status, seen_status);
            error_count_o++;
          end
          if (seen_count !== due.count) begin
            $display("%0t checker: entry_count expected %0d, actual %0d",
                     $time, due.count, seen_count);
            error_count_o++;
          end
          if (due.status == ST_FOUND) found_count_o++;
          if (due.status == ST_FULL) rejected_count_o++;
        end
      end
      pending_o = results_due.size();
    end
  end

endmodule

// ===== verif/tb_move_to_front_list_unit.sv =====
`timescale 1ns / 1ps

module tb_move_to_front_list_unit;
  import mtf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [ITEM_WIDTH-1:0] s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic        calm = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned insert_total = 0;
  int unsigned access_total = 0;
  int unsigned error_count, pending, found_count, rejected_count;
  value_t      stocked [$];
  int unsigned pick;
  value_t      key;

  always #2 clk_i = ~clk_i;

  move_to_front_list_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  move_to_front_list_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .error_count_o    (error_count),
    .pending_o        (pending),
    .found_count_o    (found_count),
    .rejected_count_o (rejected_count)
  );

  // Result side back-pressure; none during the calm stretch.
  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input kind_e kind, input value_t value);
    if (!calm) begin
      while ($urandom_range(99) < 12) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (kind == KIND_INSERT) begin
      insert_total++;
      if (stocked.size() < DEPTH) stocked.push_back(value);
    end else begin
      access_total++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, value one, extremes, duplicates, head and deep matches
    send_item(KIND_ACCESS, 5);
    send_item(KIND_INSERT, 1);
    send_item(KIND_ACCESS, 1);
    send_item(KIND_ACCESS, 0);
    send_item(KIND_INSERT, 32'sh8000_0000);
    send_item(KIND_INSERT, 32'sh7fff_ffff);
    send_item(KIND_INSERT, 0);
    send_item(KIND_INSERT, -1);
    send_item(KIND_INSERT, 1);
    send_item(KIND_ACCESS, 1);
    send_item(KIND_ACCESS, 32'sh8000_0000);
    send_item(KIND_ACCESS, 1);
    send_item(KIND_ACCESS, 32'sh7fff_ffff);
    while (stocked.size() < DEPTH) begin
      send_item(KIND_INSERT, (stocked.size() % 3 == 0) ? 7 : value_t'($urandom));
    end
    send_item(KIND_INSERT, 2);
    send_item(KIND_ACCESS, 7);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 250 && n < 400);
      pick = $urandom_range(99);
      key  = stocked[$urandom_range(stocked.size() - 1)];
      if (pick < 70) send_item(KIND_ACCESS, key);
      else if (pick < 80) send_item(KIND_ACCESS, $urandom_range(1) ? key + 1 : key - 1);
      else if (pick < 90) send_item(KIND_ACCESS, $urandom);
      else send_item(KIND_INSERT, $urandom);
    end
    s_tvalid <= 1'b0;

    // let the checker count the last beat before draining
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run: %0d inserts (%0d turned away by a full list), %0d accesses (%0d hits)",
             insert_total, rejected_count, access_total, found_count);
    $display("run: list filled to %0d entries, %0d mismatches", stocked.size(), error_count);
    if (error_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mtf_pkg.sv
rtl/core/mtf_cell.sv
rtl/core/move_to_front_list_unit.sv
verif/move_to_front_list_checker.sv
verif/tb_move_to_front_list_unit.sv
